>>> hw/rtl/i2cmts_pkg.sv
// Shared constants, request and bus action codes for the I2C master
// transaction sequencer. No dependencies.
package i2cmts_pkg;

  localparam int unsigned CmdDepth = 16;
  localparam int unsigned TxDepth  = 32;
  localparam int unsigned CmdAw    = $clog2(CmdDepth);
  localparam int unsigned TxAw     = $clog2(TxDepth);

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 32;

  typedef enum logic [2:0] {
    ReqLoadCmd  = 3'd0,
    ReqLoadTx   = 3'd1,
    ReqBeginWr  = 3'd2,
    ReqBeginRd  = 3'd3,
    ReqProbe    = 3'd4,
    ReqBusEvent = 3'd5,
    ReqTick     = 3'd6
  } req_e;

  typedef enum logic [3:0] {
    ActNone   = 4'd0,
    ActStart  = 4'd1,
    ActSend   = 4'd2,
    ActRecv   = 4'd3,
    ActAck    = 4'd4,
    ActNack   = 4'd5,
    ActStop   = 4'd6,
    ActLow    = 4'd7,
    ActReinit = 4'd8
  } action_e;

  typedef enum logic [1:0] {
    ComplNone = 2'd0,
    ComplOk   = 2'd1,
    ComplFail = 2'd2
  } compl_e;

  localparam logic [1:0] CtrlEnabledClean = 2'd2;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       accepted;
    logic [1:0] completion;
    logic       busy_res;
  } result_t;

endpackage

>>> hw/rtl/i2c_master_transaction_sequencer.sv
// I2C master transaction sequencer: top level with command and transmit byte
// memories and the phase sequencer. Depends on i2cmts_pkg.
//
// Takes one request beat per clock and returns exactly one result beat for
// each, in order. Throughput is one beat per cycle; the input stalls only
// while a finished result waits in the output register and the sink holds
// m_axis_tready low. Results are registered. The command and transmit buffers
// are memories with one write port and one registered read port: the read
// address always follows the next byte index, so the byte a bus event sends
// is already in the read register when that event arrives; a load to that
// same entry is forwarded into the read register. Buffer entries must be
// loaded before a transfer sends them. After reset the controller is off and
// busy until the first tick reinitializes it. The user must write
// watchdog_reload on the cfg port only while the block is idle (not enforced).
module i2c_master_transaction_sequencer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // entry_index[4:0], entry_byte[12:5], device_address[20:13], read_only[21],
  // command_length[26:22], tx_length[32:27], rx_length[40:33],
  // nack_seen[41], rx_byte[49:42], controller_state[51:50], zeros above
  input  logic [i2cmts_pkg::InDataW-1:0]    s_axis_tdata,
  // req_type[2:0]
  input  logic [2:0]                        s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tx_byte[7:0], rx_valid[8], rx_index[16:9], rx_data[24:17], accepted[25],
  // completion[27:26], busy_res[28], zeros above
  output logic [i2cmts_pkg::OutDataW-1:0]   m_axis_tdata,
  // bus_action[3:0]
  output logic [3:0]                        m_axis_tuser,
  // watchdog_reload write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [3:0]                        cfg_data_i
);
  import i2cmts_pkg::*;

  typedef enum logic [3:0] {
    PhIdle     = 4'd0,
    PhWrAddr   = 4'd1,
    PhCmd      = 4'd2,
    PhTxData   = 4'd3,
    PhWStop    = 4'd4,
    PhDone     = 4'd5,
    PhRdStart  = 4'd6,
    PhRdAddr   = 4'd7,
    PhRecEn    = 4'd8,
    PhRecStore = 4'd9,
    PhReRec    = 4'd10,
    PhStopRead = 4'd11
  } phase_e;

  // request fields
  req_e       req;
  logic [4:0] entry_index;
  logic [7:0] entry_byte;
  logic [7:0] device_address;
  logic       read_only;
  logic [4:0] command_length;
  logic [5:0] tx_length;
  logic [7:0] rx_length;
  logic       nack_seen;
  logic [7:0] rx_byte;
  logic [1:0] controller_state;

  assign req              = req_e'(s_axis_tuser);
  assign entry_index      = s_axis_tdata[4:0];
  assign entry_byte       = s_axis_tdata[12:5];
  assign device_address   = s_axis_tdata[20:13];
  assign read_only        = s_axis_tdata[21];
  assign command_length   = s_axis_tdata[26:22];
  assign tx_length        = s_axis_tdata[32:27];
  assign rx_length        = s_axis_tdata[40:33];
  assign nack_seen        = s_axis_tdata[41];
  assign rx_byte          = s_axis_tdata[49:42];
  assign controller_state = s_axis_tdata[51:50];

  // sequencer state
  phase_e     phase_q, phase_d;
  logic [7:0] byte_index_q, byte_index_d;
  logic [7:0] address_q, address_d;
  logic       ro_q, ro_d;
  logic [4:0] cmd_cnt_q, cmd_cnt_d;
  logic [5:0] tx_cnt_q, tx_cnt_d;
  logic [7:0] rx_cnt_q, rx_cnt_d;
  logic       busy_q, busy_d;
  logic [3:0] wd_q, wd_d;
  logic       ctrl_on_q, ctrl_on_d;
  logic [3:0] wd_reload_q;

  // byte memories
  logic [7:0] cmd_mem [CmdDepth];
  logic [7:0] tx_mem  [TxDepth];
  logic [7:0] cmd_rd_q, tx_rd_q;
  logic       cmd_we, tx_we;
  logic [CmdAw-1:0] cmd_waddr, cmd_raddr;
  logic [TxAw-1:0]  tx_waddr, tx_raddr;

  // output register
  logic       out_valid_q;
  action_e    act_q, act_d;
  result_t    res_q, res_d;
  logic       fire;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign cmd_we    = fire && (req == ReqLoadCmd) && ({3'b0, entry_index} < 8'(CmdDepth));
  assign tx_we     = fire && (req == ReqLoadTx) && ({3'b0, entry_index} < 8'(TxDepth));
  assign cmd_waddr = entry_index[CmdAw-1:0];
  assign tx_waddr  = entry_index[TxAw-1:0];
  // prefetch the entry the next bus event will send
  assign cmd_raddr = byte_index_d[CmdAw-1:0];
  assign tx_raddr  = byte_index_d[TxAw-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_we) begin
      cmd_mem[cmd_waddr] <= entry_byte;
    end
    if (tx_we) begin
      tx_mem[tx_waddr] <= entry_byte;
    end
    if (cmd_we && (cmd_waddr == cmd_raddr)) begin
      cmd_rd_q <= entry_byte;
    end else begin
      cmd_rd_q <= cmd_mem[cmd_raddr];
    end
    if (tx_we && (tx_waddr == tx_raddr)) begin
      tx_rd_q <= entry_byte;
    end else begin
      tx_rd_q <= tx_mem[tx_raddr];
    end
  end

  always_comb begin
    logic [7:0] bi_inc;
    logic       fail;
    bi_inc       = byte_index_q + 8'd1;
    fail         = 1'b0;
    phase_d      = phase_q;
    byte_index_d = byte_index_q;
    address_d    = address_q;
    ro_d         = ro_q;
    cmd_cnt_d    = cmd_cnt_q;
    tx_cnt_d     = tx_cnt_q;
    rx_cnt_d     = rx_cnt_q;
    busy_d       = busy_q;
    wd_d         = wd_q;
    ctrl_on_d    = ctrl_on_q;
    act_d        = ActNone;
    res_d        = '0;

    if (fire) begin
      case (req)
        ReqBeginWr, ReqBeginRd, ReqProbe: begin
          if (ctrl_on_q && (controller_state == CtrlEnabledClean) && !busy_q) begin
            busy_d       = 1'b1;
            wd_d         = wd_reload_q;
            address_d    = device_address;
            byte_index_d = '0;
            ro_d         = 1'b0;
            cmd_cnt_d    = '0;
            tx_cnt_d     = '0;
            rx_cnt_d     = '0;
            if (req == ReqBeginWr) begin
              cmd_cnt_d = (command_length > 5'(CmdDepth)) ? 5'(CmdDepth) : command_length;
              tx_cnt_d  = (tx_length > 6'(TxDepth)) ? 6'(TxDepth) : tx_length;
            end else if (req == ReqBeginRd) begin
              ro_d      = read_only;
              cmd_cnt_d = (command_length > 5'(CmdDepth)) ? 5'(CmdDepth) : command_length;
              rx_cnt_d  = rx_length;
            end
            phase_d        = (req == ReqBeginRd && read_only) ? PhRdAddr : PhWrAddr;
            act_d          = ActStart;
            res_d.accepted = 1'b1;
          end
        end
        ReqBusEvent: begin
          if (ctrl_on_q && (phase_q != PhIdle)) begin
            wd_d = wd_reload_q;
            case (phase_q)
              PhWrAddr: begin
                act_d         = ActSend;
                res_d.tx_byte = {address_q[7:1], 1'b0};
                phase_d       = PhCmd;
              end
              PhCmd: begin
                if (nack_seen) begin
                  fail = 1'b1;
                end else if (cmd_cnt_q == '0) begin
                  act_d   = ActStop;
                  phase_d = PhDone;
                end else begin
                  act_d         = ActSend;
                  res_d.tx_byte = (byte_index_q < 8'(CmdDepth)) ? cmd_rd_q : 8'd0;
                  byte_index_d  = bi_inc;
                  if (bi_inc >= {3'b0, cmd_cnt_q}) begin
                    byte_index_d = '0;
                    phase_d      = (rx_cnt_q != '0) ? PhRdStart : PhTxData;
                  end
                end
              end
              PhTxData: begin
                if (nack_seen) begin
                  fail = 1'b1;
                end else if (byte_index_q >= {2'b0, tx_cnt_q}) begin
                  act_d   = ActStop;
                  phase_d = PhDone;
                end else begin
                  act_d         = ActSend;
                  res_d.tx_byte = (byte_index_q < 8'(TxDepth)) ? tx_rd_q : 8'd0;
                  byte_index_d  = bi_inc;
                  if (bi_inc >= {2'b0, tx_cnt_q}) begin
                    phase_d = (rx_cnt_q == '0) ? PhWStop : PhRdStart;
                  end
                end
              end
              PhWStop, PhStopRead: begin
                act_d   = ActStop;
                phase_d = PhDone;
              end
              PhDone: begin
                busy_d           = 1'b0;
                res_d.completion = ComplOk;
                phase_d          = PhIdle;
              end
              PhRdStart: begin
                byte_index_d = '0;
                act_d        = ActStart;
                phase_d      = PhRdAddr;
              end
              PhRdAddr: begin
                act_d         = ActSend;
                res_d.tx_byte = address_q | 8'h01;
                byte_index_d  = '0;
                phase_d       = PhRecEn;
              end
              PhRecEn: begin
                if (nack_seen) begin
                  fail = 1'b1;
                end else begin
                  act_d   = ActRecv;
                  phase_d = PhRecStore;
                end
              end
              PhRecStore: begin
                res_d.rx_valid = 1'b1;
                res_d.rx_index = byte_index_q;
                res_d.rx_data  = rx_byte;
                byte_index_d   = bi_inc;
                // last byte, or the index wrapped: refuse further data
                if (bi_inc >= rx_cnt_q || bi_inc == '0) begin
                  act_d   = ActNack;
                  phase_d = PhStopRead;
                end else begin
                  act_d   = ActAck;
                  phase_d = PhReRec;
                end
              end
              PhReRec: begin
                act_d   = ActRecv;
                phase_d = PhRecStore;
              end
              default: begin
                phase_d = PhIdle;
              end
            endcase
            if (fail) begin
              act_d            = ActStop;
              res_d.completion = ComplFail;
              phase_d          = PhIdle;
              busy_d           = 1'b0;
            end
          end
        end
        ReqTick: begin
          if (!ctrl_on_q) begin
            ctrl_on_d = 1'b1;
            phase_d   = PhIdle;
            busy_d    = 1'b0;
            act_d     = ActReinit;
          end else if (busy_q) begin
            if (wd_q == '0) begin
              // stalled transfer: abort and drop the controller
              phase_d          = PhIdle;
              ctrl_on_d        = 1'b0;
              act_d            = ActLow;
              res_d.completion = ComplFail;
              wd_d             = wd_reload_q;
            end else begin
              wd_d = wd_q - 4'd1;
            end
          end
        end
        default: begin
        end
      endcase
      res_d.busy_res = busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      byte_index_q <= '0;
      address_q    <= '0;
      ro_q         <= 1'b0;
      cmd_cnt_q    <= '0;
      tx_cnt_q     <= '0;
      rx_cnt_q     <= '0;
      busy_q       <= 1'b1;
      wd_q         <= '0;
      ctrl_on_q    <= 1'b0;
      wd_reload_q  <= 4'd3;
      out_valid_q  <= 1'b0;
      act_q        <= ActNone;
      res_q        <= '0;
    end else begin
      phase_q      <= phase_d;
      byte_index_q <= byte_index_d;
      address_q    <= address_d;
      ro_q         <= ro_d;
      cmd_cnt_q    <= cmd_cnt_d;
      tx_cnt_q     <= tx_cnt_d;
      rx_cnt_q     <= rx_cnt_d;
      busy_q       <= busy_d;
      wd_q         <= wd_d;
      ctrl_on_q    <= ctrl_on_d;
      if (cfg_valid_i) begin
        wd_reload_q <= cfg_data_i;
      end
      // result payload, hold while stalled
      if (fire) begin
        out_valid_q <= 1'b1;
        act_q       <= act_d;
        res_q       <= res_d;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = act_q;
  assign m_axis_tdata  = {3'b0, res_q.busy_res, res_q.completion, res_q.accepted,
                          res_q.rx_data, res_q.rx_index, res_q.rx_valid, res_q.tx_byte};

  a_busy_in_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PhIdle) |-> busy_q)
    else $error("transfer phase active while not busy");

  a_off_is_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_on_q |-> (phase_q == PhIdle))
    else $error("controller off with a transfer phase active");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.accepted) |-> (act_q == ActStart && res_q.busy_res))
    else $error("accepted begin without start and busy");

  a_reinit_clears_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && req == ReqTick && !ctrl_on_q) |=> (ctrl_on_q && !busy_q))
    else $error("reinit tick did not enable and clear busy");

endmodule

>>> sim/i2c_sequencer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the I2C master transaction sequencer: watches the request,
// result and watchdog_reload channels, predicts every result beat and compares
// it field by field. Depends on i2cmts_pkg.
module i2c_sequencer_checker (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                req_valid_i,
  input  logic                                req_ready_i,
  input  logic [i2cmts_pkg::InDataW-1:0]      req_data_i,
  input  logic [2:0]                          req_user_i,
  input  logic                                res_valid_i,
  input  logic                                res_ready_i,
  input  logic [i2cmts_pkg::OutDataW-1:0]     res_data_i,
  input  logic [3:0]                          res_user_i,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [3:0]                          cfg_data_i,
  output int                                  fail_count_o,
  output int                                  pending_o
);
  import i2cmts_pkg::*;

  typedef enum logic [3:0] {
    PhIdle, PhWrAddr, PhCmd, PhTxData, PhWStop, PhDone,
    PhRdStart, PhRdAddr, PhRecEn, PhRecStore, PhReRec, PhStopRead
  } phase_e;

  typedef struct {
    action_e    action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_data;
    logic       accepted;
    compl_e     completion;
    logic       busy;
  } outcome_t;

  outcome_t   outcome_q [$];
  outcome_t   oldest;
  int         fails;
  int         field_errs;

  phase_e     phase;
  logic [7:0] byte_idx;
  logic [7:0] addr_latch;
  logic       ronly_latch;
  logic [4:0] cmd_count;
  logic [5:0] tx_count;
  logic [7:0] rx_count;
  logic       busy;
  logic       ctrl_on;
  logic [3:0] wd_count;
  logic [3:0] wd_reload;
  logic [7:0] cmd_mem [CmdDepth];
  logic [7:0] tx_mem  [TxDepth];

  // NACK at a checked step: stop and report failure
  function automatic outcome_t nack_abort(input outcome_t o);
    o.action     = ActStop;
    o.completion = ComplFail;
    phase        = PhIdle;
    busy         = 1'b0;
    return o;
  endfunction

  function automatic outcome_t next_outcome(input req_e req,
                                            input logic [InDataW-1:0] d);
    outcome_t   o;
    logic [4:0] eidx;
    logic [7:0] ebyte;
    logic [7:0] addr;
    logic       ronly;
    logic [4:0] clen;
    logic [5:0] tlen;
    logic [7:0] rlen;
    logic       nack;
    logic [7:0] rxb;
    logic [1:0] cstate;
    eidx   = d[4:0];
    ebyte  = d[12:5];
    addr   = d[20:13];
    ronly  = d[21];
    clen   = d[26:22];
    tlen   = d[32:27];
    rlen   = d[40:33];
    nack   = d[41];
    rxb    = d[49:42];
    cstate = d[51:50];

    o.action     = ActNone;
    o.tx_byte    = '0;
    o.rx_valid   = 1'b0;
    o.rx_index   = '0;
    o.rx_data    = '0;
    o.accepted   = 1'b0;
    o.completion = ComplNone;

    case (req)
      ReqLoadCmd: if (eidx < CmdDepth) cmd_mem[eidx[CmdAw-1:0]] = ebyte;
      ReqLoadTx:  if (eidx < TxDepth) tx_mem[eidx[TxAw-1:0]] = ebyte;
      ReqBeginWr, ReqBeginRd, ReqProbe: begin
        if (ctrl_on && cstate == CtrlEnabledClean && !busy) begin
          busy        = 1'b1;
          wd_count    = wd_reload;
          addr_latch  = addr;
          byte_idx    = '0;
          ronly_latch = 1'b0;
          cmd_count   = '0;
          tx_count    = '0;
          rx_count    = '0;
          if (req == ReqBeginWr) begin
            cmd_count = (clen > CmdDepth) ? 5'(CmdDepth) : clen;
            tx_count  = (tlen > TxDepth) ? 6'(TxDepth) : tlen;
          end else if (req == ReqBeginRd) begin
            ronly_latch = ronly;
            cmd_count   = (clen > CmdDepth) ? 5'(CmdDepth) : clen;
            rx_count    = rlen;
          end
          phase      = ronly_latch ? PhRdAddr : PhWrAddr;
          o.action   = ActStart;
          o.accepted = 1'b1;
        end
      end
      ReqBusEvent: begin
        if (ctrl_on && phase != PhIdle) begin
          wd_count = wd_reload;
          case (phase)
            PhWrAddr: begin
              // direction bit cleared for write
              o.action  = ActSend;
              o.tx_byte = {addr_latch[7:1], 1'b0};
              phase     = PhCmd;
            end
            PhCmd: begin
              if (nack) begin
                o = nack_abort(o);
              end else if (cmd_count == 0) begin
                o.action = ActStop;
                phase    = PhDone;
              end else begin
                o.action  = ActSend;
                o.tx_byte = (byte_idx < CmdDepth) ? cmd_mem[byte_idx[CmdAw-1:0]] : 8'h00;
                byte_idx  = byte_idx + 8'd1;
                if (byte_idx >= cmd_count) begin
                  byte_idx = '0;
                  phase    = (rx_count != 0) ? PhRdStart : PhTxData;
                end
              end
            end
            PhTxData: begin
              if (nack) begin
                o = nack_abort(o);
              end else if (byte_idx >= tx_count) begin
                o.action = ActStop;
                phase    = PhDone;
              end else begin
                o.action  = ActSend;
                o.tx_byte = (byte_idx < TxDepth) ? tx_mem[byte_idx[TxAw-1:0]] : 8'h00;
                byte_idx  = byte_idx + 8'd1;
                if (byte_idx >= tx_count) phase = (rx_count == 0) ? PhWStop : PhRdStart;
              end
            end
            PhWStop, PhStopRead: begin
              o.action = ActStop;
              phase    = PhDone;
            end
            PhDone: begin
              busy         = 1'b0;
              o.completion = ComplOk;
              phase        = PhIdle;
            end
            PhRdStart: begin
              byte_idx = '0;
              o.action = ActStart;
              phase    = PhRdAddr;
            end
            PhRdAddr: begin
              // direction bit set for read
              o.action  = ActSend;
              o.tx_byte = {addr_latch[7:1], 1'b1};
              byte_idx  = '0;
              phase     = PhRecEn;
            end
            PhRecEn: begin
              if (nack) begin
                o = nack_abort(o);
              end else begin
                o.action = ActRecv;
                phase    = PhRecStore;
              end
            end
            PhRecStore: begin
              o.rx_valid = 1'b1;
              o.rx_index = byte_idx;
              o.rx_data  = rxb;
              byte_idx   = byte_idx + 8'd1;
              // last byte (or index wrap) gets a NACK
              if (byte_idx >= rx_count || byte_idx == 0) begin
                o.action = ActNack;
                phase    = PhStopRead;
              end else begin
                o.action = ActAck;
                phase    = PhReRec;
              end
            end
            PhReRec: begin
              o.action = ActRecv;
              phase    = PhRecStore;
            end
            default: phase = PhIdle;
          endcase
        end
      end
      ReqTick: begin
        if (!ctrl_on) begin
          ctrl_on  = 1'b1;
          phase    = PhIdle;
          busy     = 1'b0;
          o.action = ActReinit;
        end else if (busy) begin
          if (wd_count == 0) begin
            phase        = PhIdle;
            ctrl_on      = 1'b0;
            o.action     = ActLow;
            o.completion = ComplFail;
            wd_count     = wd_reload;
          end else begin
            wd_count = wd_count - 4'd1;
          end
        end
      end
      default: ;
    endcase

    o.busy = busy;
    return o;
  endfunction

  function automatic int field_diff(input string name, input int unsigned want,
                                    input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase       = PhIdle;
      byte_idx    = '0;
      addr_latch  = '0;
      ronly_latch = 1'b0;
      cmd_count   = '0;
      tx_count    = '0;
      rx_count    = '0;
      busy        = 1'b1;
      ctrl_on     = 1'b0;
      wd_count    = '0;
      wd_reload   = 4'd3;
      fails       = 0;
      outcome_q.delete();
    end else begin
      // retire the result beat first; a request beat at this edge cannot be its cause
      if (res_valid_i && res_ready_i) begin
        if (outcome_q.size() == 0) begin
          $display("%0t ns: result beat with nothing expected, bus_action %0d",
                   $time, res_user_i);
          fails++;
        end else begin
          oldest     = outcome_q.pop_front();
          field_errs = field_diff("bus_action", 32'(oldest.action), 32'(res_user_i))
                     + field_diff("tx_byte", 32'(oldest.tx_byte), 32'(res_data_i[7:0]))
                     + field_diff("rx_valid", 32'(oldest.rx_valid), 32'(res_data_i[8]))
                     + field_diff("rx_index", 32'(oldest.rx_index), 32'(res_data_i[16:9]))
                     + field_diff("rx_data", 32'(oldest.rx_data), 32'(res_data_i[24:17]))
                     + field_diff("accepted", 32'(oldest.accepted), 32'(res_data_i[25]))
                     + field_diff("completion", 32'(oldest.completion),
                                  32'(res_data_i[27:26]))
                     + field_diff("busy_res", 32'(oldest.busy), 32'(res_data_i[28]));
          fails += field_errs;
        end
      end
      if (cfg_valid_i && cfg_ready_i) wd_reload = cfg_data_i;
      if (req_valid_i && req_ready_i) begin
        outcome_q.push_back(next_outcome(req_e'(req_user_i), req_data_i));
      end
    end
    fail_count_o <= fails;
    pending_o    <= outcome_q.size();
  end

endmodule

>>> sim/i2c_master_transaction_sequencer_test.sv
`timescale 1ns / 1ps
// Testbench top for the I2C master transaction sequencer: drives request beats,
// watchdog_reload writes and result backpressure, and reports the verdict.
// Depends on i2cmts_pkg, the sequencer RTL and i2c_sequencer_checker.
module i2c_master_transaction_sequencer_test;
  import i2cmts_pkg::*;

  localparam int         StallLimit   = 4000;
  localparam int         PhaseItems   = 140;
  localparam logic [1:0] CtrlDisabled = 2'd0;
  localparam logic [1:0] CtrlNotClean = 2'd1;

  typedef struct {
    logic [4:0] entry_index;
    logic [7:0] entry_byte;
    logic [7:0] device_address;
    logic       read_only;
    logic [4:0] command_length;
    logic [5:0] tx_length;
    logic [7:0] rx_length;
    logic       nack_seen;
    logic [7:0] rx_byte;
    logic [1:0] controller_state;
  } request_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata;
  logic [2:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [3:0]            m_axis_tuser;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [3:0]            cfg_data_i;

  int                    fail_count;
  int                    pending;
  int                    items_sent;
  int                    idle_cycles;
  bit                    gaps_on;

  i2c_master_transaction_sequencer DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  i2c_sequencer_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_i  (s_axis_tready),
    .req_data_i   (s_axis_tdata),
    .req_user_i   (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result sink: random stalls with occasional long stretches of steady ready
  initial begin
    int unsigned span;
    m_axis_tready = 1'b0;
    @(negedge clk_i);
    forever begin
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
      m_axis_tready <= 1'b1;
      repeat (span) @(negedge clk_i);
      span = pick_gap();
      if (span != 0) begin
        m_axis_tready <= 1'b0;
        repeat (span) @(negedge clk_i);
      end
    end
  end

  // drop the run if no beat moves on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [InDataW-1:0] pack_request(input request_t r);
    return {4'b0, r.controller_state, r.rx_byte, r.nack_seen, r.rx_length, r.tx_length,
            r.command_length, r.read_only, r.device_address, r.entry_byte, r.entry_index};
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.entry_index      = 5'($urandom_range(0, 31));
    r.entry_byte       = 8'($urandom_range(0, 255));
    r.device_address   = 8'($urandom_range(0, 255));
    r.read_only        = 1'($urandom_range(0, 1));
    r.command_length   = 5'($urandom_range(0, 31));
    r.tx_length        = 6'($urandom_range(0, 63));
    r.rx_length        = 8'($urandom_range(0, 255));
    r.nack_seen        = 1'($urandom_range(0, 1));
    r.rx_byte          = 8'($urandom_range(0, 255));
    r.controller_state = 2'($urandom_range(0, 2));
    return r;
  endfunction

  // bus events a clean transfer needs from begin to completion
  function automatic int unsigned events_needed(input req_e kind, input request_t r);
    int unsigned c;
    int unsigned t;
    int unsigned n;
    c = (r.command_length > CmdDepth) ? CmdDepth : r.command_length;
    t = (r.tx_length > TxDepth) ? TxDepth : r.tx_length;
    n = (r.rx_length == 0) ? 1 : r.rx_length;
    if (kind == ReqBeginWr) return (c == 0) ? 3 : 3 + c + t;
    if (kind == ReqBeginRd) begin
      if (r.read_only) return 2 * n + 3;
      if (c == 0 || r.rx_length == 0) return 3 + c;
      return c + 2 * n + 5;
    end
    return 3;
  endfunction

  task automatic hold_sender(input int unsigned cycles);
    if (cycles != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (cycles - 1) @(negedge clk_i);
    end
  endtask

  task automatic send(input req_e kind, input request_t r);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= pack_request(r);
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
    if (gaps_on) hold_sender(pick_gap());
  endtask

  // hold requests until every expected result beat is out, then settle
  task automatic drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic write_reload(input logic [3:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed_transfer(input req_e kind, input request_t r,
                                   input int events, input int nack_at);
    request_t ev;
    send(kind, r);
    for (int i = 0; i < events; i++) begin
      ev           = random_request();
      ev.nack_seen = (i == nack_at);
      send(ReqBusEvent, ev);
    end
  endtask

  task automatic run_transfer();
    request_t    r;
    request_t    ev;
    req_e        kind;
    int unsigned roll;
    int unsigned steps;
    r = random_request();
    r.controller_state = CtrlEnabledClean;
    roll = $urandom_range(0, 9);
    kind = (roll < 4) ? ReqBeginWr : (roll < 8) ? ReqBeginRd : ReqProbe;
    r.command_length = 5'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 4) :
                          $urandom_range(0, 31));
    r.tx_length      = 6'(($urandom_range(0, 7) != 0) ? $urandom_range(0, 5) :
                          $urandom_range(0, 63));
    roll = $urandom_range(0, 99);
    r.rx_length = 8'((roll < 80) ? $urandom_range(0, 6) :
                     (roll < 97) ? $urandom_range(7, 40) : $urandom_range(128, 255));
    // reinitialize after an abort; no effect on an idle controller
    send(ReqTick, random_request());
    send(kind, r);
    steps = events_needed(kind, r) + $urandom_range(0, 1);
    repeat (steps) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) send(ReqTick, random_request());
      else if (roll < 8) send((roll < 6) ? ReqLoadCmd : ReqLoadTx, random_request());
      ev           = random_request();
      ev.nack_seen = ($urandom_range(0, 39) == 0);
      send(ReqBusEvent, ev);
    end
  endtask

  initial begin
    request_t    r;
    int unsigned reload_plan [5];
    int unsigned phase_end;
    int unsigned roll;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = ReqLoadCmd;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    gaps_on       = 1'b1;
    items_sent    = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // load every buffer entry so no transfer sends an unloaded byte
    for (int i = 0; i < TxDepth; i++) begin
      r = random_request();
      r.entry_index = 5'(i);
      if (i < CmdDepth) send(ReqLoadCmd, r);
      send(ReqLoadTx, r);
    end

    // controller is off after reset
    r = random_request();
    r.controller_state = CtrlEnabledClean;
    send(ReqBeginWr, r);
    send(ReqBusEvent, random_request());
    send(ReqTick, random_request());
    send(ReqTick, random_request());
    r.controller_state = CtrlDisabled;
    send(ReqProbe, r);
    r.controller_state = CtrlNotClean;
    send(ReqBeginRd, r);
    // out-of-range command load, last transmit entry
    r.entry_index = 5'd31;
    r.entry_byte  = 8'hFF;
    send(ReqLoadCmd, r);
    r.entry_byte  = 8'h00;
    send(ReqLoadTx, r);

    r = random_request();
    r.controller_state = CtrlEnabledClean;
    r.device_address   = 8'hFF;
    directed_transfer(ReqProbe, r, 3, -1);
    // zero transmit length
    r.device_address = 8'h00;
    r.command_length = 5'd1;
    r.tx_length      = 6'd0;
    directed_transfer(ReqBeginWr, r, 4, -1);
    // NACK seen at the step that would send the first command byte
    r.command_length = 5'd2;
    r.tx_length      = 6'd32;
    directed_transfer(ReqBeginWr, r, 2, 1);
    // read-only with zero receive length
    r.read_only = 1'b1;
    r.rx_length = 8'd0;
    directed_transfer(ReqBeginRd, r, 5, -1);
    // read without command bytes
    r.read_only      = 1'b0;
    r.command_length = 5'd0;
    r.rx_length      = 8'd3;
    directed_transfer(ReqBeginRd, r, 3, -1);
    // watchdog abort, then reinit
    write_reload(4'd0);
    r.command_length = 5'd31;
    r.tx_length      = 6'd63;
    directed_transfer(ReqBeginWr, r, 1, -1);
    send(ReqTick, random_request());
    send(ReqTick, random_request());

    reload_plan = '{15, 0, 9, 1, 3};
    reload_plan[3] = $urandom_range(0, 15);
    for (int p = 0; p < 5; p++) begin
      write_reload(4'(reload_plan[p]));
      gaps_on   = (p != 2);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          run_transfer();
        end else if (roll < 95) begin
          repeat ($urandom_range(1, 4)) send(req_e'($urandom_range(0, 6)), random_request());
        end else begin
          drain();
        end
      end
    end

    drain();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/i2cmts_pkg.sv
hw/rtl/i2c_master_transaction_sequencer.sv
sim/i2c_sequencer_checker.sv
sim/i2c_master_transaction_sequencer_test.sv
